// ===== rtl/bls_pkg.sv =====
package bls_pkg;

  typedef enum logic [2:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_PEEK   = 3'd2,
    MODE_TOP    = 3'd3,
    MODE_BOTTOM = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_BAD_POS   = 2'd3
  } status_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_WAIT = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

  localparam int unsigned ModeWidth   = 3;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned PosWidth    = 5;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CapWidth    = 5;
  localparam logic [CapWidth-1:0] CapReset = 5'd16;

endpackage

// ===== rtl/bls_if.sv =====
interface bls_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [bls_pkg::ModeWidth-1:0]  mode;
  logic signed [bls_pkg::ValueWidth-1:0] push_value;
  logic        [bls_pkg::PosWidth-1:0]   position;

  modport source (output valid, output mode, output push_value, output position, input ready);
  modport sink   (input valid, input mode, input push_value, input position, output ready);
endinterface

interface bls_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bls_pkg::ValueWidth-1:0]  data;
  logic        [bls_pkg::StatusWidth-1:0] status;
  logic                                   is_empty;
  logic                                   is_full;

  modport source (output valid, output data, output status, output is_empty, output is_full,
                  input ready);
  modport sink   (input valid, input data, input status, input is_empty, input is_full,
                  output ready);
endinterface

// ===== rtl/bls_ram.sv =====
module bls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bls_ctrl.sv =====
module bls_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bls_pkg::cmd_t cmd_o
);

  bls_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bls_pkg::CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.load   = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      bls_pkg::CTRL_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = bls_pkg::CTRL_WAIT;
        end
      end
      bls_pkg::CTRL_WAIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = bls_pkg::CTRL_IDLE;
        end
      end
      default: begin
        state_d = bls_pkg::CTRL_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/bls_datapath.sv =====
module bls_datapath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bls_pkg::cmd_t                         cmd_i,
  input  logic                                  cfg_we_i,
  input  logic        [bls_pkg::CapWidth-1:0]   cfg_wdata_i,
  input  logic        [bls_pkg::ModeWidth-1:0]  mode_i,
  input  logic signed [bls_pkg::ValueWidth-1:0] push_value_i,
  input  logic        [bls_pkg::PosWidth-1:0]   position_i,
  output logic signed [bls_pkg::ValueWidth-1:0] data_o,
  output logic        [bls_pkg::StatusWidth-1:0] status_o,
  output logic                                  is_empty_o,
  output logic                                  is_full_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (FW > bls_pkg::CapWidth) ? FW : bls_pkg::CapWidth;
  localparam int unsigned VW   = bls_pkg::ValueWidth;
  localparam logic [CMPW-1:0] DepthC = CMPW'(DEPTH);
  localparam logic [CMPW-1:0] OneC   = CMPW'(1);

  logic [bls_pkg::CapWidth-1:0] cap_q;
  logic [FW-1:0]                fill_q, fill_d;
  logic                         use_ram_q, use_ram_d;
  logic [VW-1:0]                const_q, const_d;
  bls_pkg::status_e             status_q, status_d;
  logic                         empty_q, full_q;

  logic [VW-1:0]                data_out_q;
  logic [bls_pkg::StatusWidth-1:0] status_out_q;
  logic                         empty_out_q, full_out_q;

  logic [CMPW-1:0]       cap_ext, cap_eff, fill_ext, fill_new_ext, pos_ext;
  logic                  full_now;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [63:0]           push_wide, rdata_wide, mask_wide;

  assign cap_ext      = CMPW'(cap_q);
  assign cap_eff      = (cap_q == '0) ? OneC : ((cap_ext > DepthC) ? DepthC : cap_ext);
  assign fill_ext     = CMPW'(fill_q);
  assign fill_new_ext = CMPW'(fill_d);
  assign pos_ext      = CMPW'(position_i);
  assign full_now     = fill_ext >= cap_eff;

  assign push_wide = 64'(unsigned'(push_value_i));
  assign ram_wdata = push_wide[DATA_WIDTH-1:0];
  assign mask_wide = 64'({DATA_WIDTH{1'b1}});

  always_comb begin
    fill_d    = fill_q;
    use_ram_d = 1'b0;
    const_d   = '0;
    status_d  = bls_pkg::STATUS_OK;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = fill_q[AW-1:0];
    ram_raddr = '0;
    unique case (bls_pkg::mode_e'(mode_i))
      bls_pkg::MODE_PUSH: begin
        if (full_now) begin
          status_d = bls_pkg::STATUS_OVERFLOW;
        end else begin
          ram_we = cmd_i.accept;
          fill_d = fill_q + FW'(1);
        end
      end
      bls_pkg::MODE_POP: begin
        if (fill_q == '0) begin
          status_d = bls_pkg::STATUS_UNDERFLOW;
          const_d  = mask_wide[VW-1:0];
        end else begin
          fill_d    = fill_q - FW'(1);
          ram_re    = cmd_i.accept;
          use_ram_d = 1'b1;
          ram_raddr = fill_d[AW-1:0];
        end
      end
      bls_pkg::MODE_PEEK: begin
        if (position_i == '0 || pos_ext > fill_ext) begin
          status_d = bls_pkg::STATUS_BAD_POS;
        end else begin
          ram_re    = cmd_i.accept;
          use_ram_d = 1'b1;
          ram_raddr = AW'(fill_ext - pos_ext);
        end
      end
      bls_pkg::MODE_TOP: begin
        if (fill_q == '0) begin
          status_d = bls_pkg::STATUS_UNDERFLOW;
        end else begin
          ram_re    = cmd_i.accept;
          use_ram_d = 1'b1;
          ram_raddr = AW'(fill_ext - OneC);
        end
      end
      bls_pkg::MODE_BOTTOM: begin
        if (fill_q == '0) begin
          status_d = bls_pkg::STATUS_UNDERFLOW;
        end else begin
          ram_re    = cmd_i.accept;
          use_ram_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  bls_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rdata_wide = 64'(ram_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= bls_pkg::CapReset;
      fill_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      use_ram_q <= use_ram_d;
      const_q   <= const_d;
      status_q  <= status_d;
      empty_q   <= (fill_d == '0);
      full_q    <= (fill_new_ext >= cap_eff);
    end
    if (cmd_i.load) begin
      data_out_q   <= use_ram_q ? rdata_wide[VW-1:0] : const_q;
      status_out_q <= status_q;
      empty_out_q  <= empty_q;
      full_out_q   <= full_q;
    end
  end

  assign data_o     = signed'(data_out_q);
  assign status_o   = status_out_q;
  assign is_empty_o = empty_out_q;
  assign is_full_o  = full_out_q;

endmodule

// ===== rtl/bounded_lifo_stack.sv =====
// Channel    Direction  Payload                              Handshake
// in_i       sink       mode, push_value, position           valid / ready
// out_o      source     data, status, is_empty, is_full      valid / ready
// cfg        write      cfg_wdata_i (capacity)               cfg_we_i
//
// Each request runs in order: the memory access and fill update in the cycle of
// acceptance, then the registered memory read loads the result register.
// A new request is taken while an earlier result still waits in the output register.
// A stalled output holds the second request in its wait state until the slot frees.
// Reset clears the fill level and sets the capacity to sixteen; the entries are not cleared.
module bounded_lifo_stack #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bls_pkg::CapWidth-1:0]  cfg_wdata_i,
  bls_in_if.sink                        in_i,
  bls_out_if.source                     out_o
);

  bls_pkg::cmd_t cmd;
  logic          in_ready, out_valid;

  bls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  bls_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mode_i       (in_i.mode),
    .push_value_i (in_i.push_value),
    .position_i   (in_i.position),
    .data_o       (out_o.data),
    .status_o     (out_o.status),
    .is_empty_o   (out_o.is_empty),
    .is_full_o    (out_o.is_full)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("Request accepted while the previous one was still in progress.");

  a_result_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("Result appeared without a request in progress.");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.is_empty && out_o.is_full))
    else $error("Result reports a stack that is both empty and full.");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == bls_pkg::STATUS_OVERFLOW) |-> out_o.is_full)
    else $error("Overflow reported on a stack that is not full.");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import bls_pkg::*;

  localparam int unsigned StackDepth    = 16;
  localparam int unsigned RandomTarget  = 1550;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned ReportLimit   = 10;

  localparam logic [ModeWidth-1:0] ModeSpareLo  = 3'd5;
  localparam logic [ModeWidth-1:0] ModeSpareMid = 3'd6;
  localparam logic [ModeWidth-1:0] ModeSpareHi  = 3'd7;

  typedef struct packed {
    logic [ValueWidth-1:0] data;
    status_e               status;
    logic                  empty;
    logic                  full;
  } stack_result_t;

  typedef struct {
    bit                    is_cfg;
    logic [CapWidth-1:0]   cap;
    logic [ModeWidth-1:0]  mode;
    logic [ValueWidth-1:0] value;
    logic [PosWidth-1:0]   pos;
    bit                    pinned;
    stack_result_t         want;
  } script_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CapWidth-1:0] cfg_wdata_i;

  bls_in_if  in_if ();
  bls_out_if out_if ();

  bounded_lifo_stack dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Shadow of the stack, kept in step with every accepted request.
  logic [ValueWidth-1:0] stack_entries [StackDepth];
  int unsigned           stack_fill   = 0;
  logic [CapWidth-1:0]   capacity_reg = CapReset;

  stack_result_t expected_results [$];
  script_row_t   script [$];

  bit            req_pinned;
  stack_result_t req_want;

  int unsigned requests_sent  = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned settings_count = 0;
  int unsigned burst_left     = 12;
  int unsigned depth_guess    = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned status_tally [4];

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int unsigned usable_slots(logic [CapWidth-1:0] cap);
    if (cap == 0) return 1;
    if (cap > StackDepth) return StackDepth;
    return cap;
  endfunction

  function automatic stack_result_t apply_request(logic [ModeWidth-1:0]  mode,
                                                  logic [ValueWidth-1:0] value,
                                                  logic [PosWidth-1:0]   pos);
    stack_result_t res;
    int unsigned   slots;
    slots      = usable_slots(capacity_reg);
    res.data   = '0;
    res.status = STATUS_OK;
    case (mode)
      MODE_PUSH: begin
        if (stack_fill >= slots) begin
          res.status = STATUS_OVERFLOW;
        end else begin
          stack_entries[stack_fill] = value;
          stack_fill++;
        end
      end
      MODE_POP: begin
        if (stack_fill == 0) begin
          res.status = STATUS_UNDERFLOW;
          res.data   = '1;
        end else begin
          stack_fill--;
          res.data = stack_entries[stack_fill];
        end
      end
      MODE_PEEK: begin
        if (pos == 0 || pos > stack_fill) res.status = STATUS_BAD_POS;
        else res.data = stack_entries[stack_fill - pos];
      end
      MODE_TOP: begin
        if (stack_fill == 0) res.status = STATUS_UNDERFLOW;
        else res.data = stack_entries[stack_fill - 1];
      end
      MODE_BOTTOM: begin
        if (stack_fill == 0) res.status = STATUS_UNDERFLOW;
        else res.data = stack_entries[0];
      end
      default: ;
    endcase
    res.empty = (stack_fill == 0);
    res.full  = (stack_fill >= slots);
    return res;
  endfunction

  function automatic script_row_t req_row(logic [ModeWidth-1:0] mode, logic [ValueWidth-1:0] value,
                                          logic [PosWidth-1:0] pos, bit pinned,
                                          logic [ValueWidth-1:0] data, status_e status,
                                          logic empty, logic full);
    script_row_t row;
    row.is_cfg      = 1'b0;
    row.cap         = '0;
    row.mode        = mode;
    row.value       = value;
    row.pos         = pos;
    row.pinned      = pinned;
    row.want.data   = data;
    row.want.status = status;
    row.want.empty  = empty;
    row.want.full   = full;
    return row;
  endfunction

  function automatic script_row_t cap_row(logic [CapWidth-1:0] cap);
    script_row_t row;
    row     = req_row(MODE_PUSH, '0, '0, 1'b0, '0, STATUS_OK, 1'b0, 1'b0);
    row.is_cfg = 1'b1;
    row.cap    = cap;
    return row;
  endfunction

  task automatic issue_request(input logic [ModeWidth-1:0] mode, input logic [ValueWidth-1:0] value,
                               input logic [PosWidth-1:0] pos, input bit pinned,
                               input stack_result_t want);
    in_if.valid      <= 1'b1;
    in_if.mode       <= mode;
    in_if.push_value <= value;
    in_if.position   <= pos;
    req_pinned       <= pinned;
    req_want         <= want;
    do @(posedge clk_i); while (!in_if.ready);
    requests_sent++;
    burst_left--;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 60);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (results_seen < requests_sent) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapWidth-1:0] cap);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    depth_guess = stack_fill;
    settings_count++;
  endtask

  // Prediction on every accepted request, checking on every accepted result.
  always @(posedge clk_i) begin
    stack_result_t predicted;
    stack_result_t got;
    stack_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) capacity_reg = cfg_wdata_i;
      if (in_if.valid && in_if.ready) begin
        predicted = apply_request(in_if.mode, in_if.push_value, in_if.position);
        want      = req_pinned ? req_want : predicted;
        status_tally[want.status]++;
        expected_results.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        got.data   = out_if.data;
        got.status = status_e'(out_if.status);
        got.empty  = out_if.is_empty;
        got.full   = out_if.is_full;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("Unexpected result %0d: data %h status %0d empty %b full %b",
                     results_seen, got.data, got.status, got.empty, got.full);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
              $display("Result %0d: expected data %h status %0d empty %b full %b",
                       results_seen, want.data, want.status, want.empty, want.full);
              $display("  got data %h status %0d empty %b full %b",
                       got.data, got.status, got.empty, got.full);
            end
          end
        end
      end
    end
  end

  // The receiver stalls on a rotating pattern that changes every so often.
  initial begin
    logic [15:0] stall_pattern;
    out_if.ready = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0:       stall_pattern = 16'hFFFF;
        1:       stall_pattern = 16'(($urandom) | 32'h1);
        2:       stall_pattern = 16'h00FF;
        default: stall_pattern = 16'h8001;
      endcase
      repeat ($urandom_range(32, 200)) begin
        @(posedge clk_i);
        out_if.ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  initial begin
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned           random_sent;
    int unsigned           push_pct;
    int unsigned           phase_len;
    int unsigned           pick;
    logic [CapWidth-1:0]   cap;
    logic [ModeWidth-1:0]  mode;
    logic [ValueWidth-1:0] value;
    logic [PosWidth-1:0]   pos;
    stack_result_t         none;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.mode       = '0;
    in_if.push_value = '0;
    in_if.position   = '0;
    req_pinned       = 1'b0;
    none             = '{data: '0, status: STATUS_OK, empty: 1'b0, full: 1'b0};
    req_want         = none;

    script.push_back(req_row(MODE_POP, '0, '0, 1, 32'hFFFF_FFFF, STATUS_UNDERFLOW, 1, 0));
    script.push_back(req_row(MODE_TOP, '0, '0, 1, '0, STATUS_UNDERFLOW, 1, 0));
    script.push_back(req_row(MODE_BOTTOM, '0, '0, 1, '0, STATUS_UNDERFLOW, 1, 0));
    script.push_back(req_row(MODE_PEEK, '0, 5'd1, 1, '0, STATUS_BAD_POS, 1, 0));
    script.push_back(req_row(MODE_PUSH, 32'h7FFF_FFFF, '0, 1, '0, STATUS_OK, 0, 0));
    script.push_back(req_row(MODE_PUSH, 32'h8000_0000, '0, 1, '0, STATUS_OK, 0, 0));
    script.push_back(req_row(MODE_TOP, '0, '0, 1, 32'h8000_0000, STATUS_OK, 0, 0));
    script.push_back(req_row(MODE_BOTTOM, '0, '0, 1, 32'h7FFF_FFFF, STATUS_OK, 0, 0));
    script.push_back(req_row(MODE_PEEK, '0, 5'd2, 1, 32'h7FFF_FFFF, STATUS_OK, 0, 0));
    script.push_back(req_row(MODE_PEEK, '0, 5'd0, 1, '0, STATUS_BAD_POS, 0, 0));
    script.push_back(req_row(MODE_PEEK, '0, 5'd3, 1, '0, STATUS_BAD_POS, 0, 0));
    script.push_back(req_row(MODE_PEEK, '0, 5'd31, 1, '0, STATUS_BAD_POS, 0, 0));
    script.push_back(req_row(ModeSpareLo, 32'hFFFF_FFFF, 5'd31, 1, '0, STATUS_OK, 0, 0));
    script.push_back(req_row(ModeSpareHi, '0, 5'd1, 1, '0, STATUS_OK, 0, 0));
    script.push_back(req_row(MODE_PUSH, 32'hFFFF_FFFF, '0, 0, '0, STATUS_OK, 0, 0));
    script.push_back(req_row(MODE_PEEK, '0, 5'd1, 0, '0, STATUS_OK, 0, 0));
    script.push_back(req_row(MODE_POP, '0, '0, 1, 32'hFFFF_FFFF, STATUS_OK, 0, 0));
    script.push_back(req_row(MODE_POP, '0, '0, 1, 32'h8000_0000, STATUS_OK, 0, 0));
    script.push_back(req_row(MODE_POP, '0, '0, 1, 32'h7FFF_FFFF, STATUS_OK, 1, 0));
    script.push_back(cap_row(5'd0));
    script.push_back(req_row(MODE_PUSH, 32'h0000_1234, '0, 1, '0, STATUS_OK, 0, 1));
    script.push_back(req_row(MODE_PUSH, 32'h0000_5678, '0, 1, '0, STATUS_OVERFLOW, 0, 1));
    script.push_back(cap_row(5'd31));
    script.push_back(req_row(MODE_PUSH, 32'hA5A5_A5A5, '0, 0, '0, STATUS_OK, 0, 0));
    script.push_back(req_row(MODE_PUSH, 32'h5A5A_5A5A, '0, 0, '0, STATUS_OK, 0, 0));
    script.push_back(cap_row(5'd2));
    script.push_back(req_row(MODE_PUSH, 32'h0000_0001, '0, 1, '0, STATUS_OVERFLOW, 0, 1));
    script.push_back(req_row(MODE_POP, '0, '0, 1, 32'h5A5A_5A5A, STATUS_OK, 0, 1));
    script.push_back(req_row(MODE_POP, '0, '0, 1, 32'hA5A5_A5A5, STATUS_OK, 0, 0));
    script.push_back(req_row(ModeSpareMid, '0, '0, 1, '0, STATUS_OK, 0, 0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        write_capacity(script[i].cap);
      end else begin
        issue_request(script[i].mode, script[i].value, script[i].pos, script[i].pinned,
                      script[i].want);
      end
    end

    // Random phases: each starts from a drained block with a fresh capacity and its own
    // balance of pushes against the other operations.
    random_sent = 0;
    while (random_sent < RandomTarget) begin
      case ($urandom_range(0, 9))
        0:       cap = 5'd0;
        1:       cap = 5'd1;
        2:       cap = 5'd16;
        3:       cap = 5'd17;
        4:       cap = 5'd31;
        default: cap = CapWidth'($urandom_range(2, 16));
      endcase
      write_capacity(cap);
      case ($urandom_range(0, 3))
        0:       push_pct = 20;
        1:       push_pct = 45;
        2:       push_pct = 55;
        default: push_pct = 80;
      endcase
      phase_len = $urandom_range(30, 150);
      repeat (phase_len) begin
        value = $urandom;
        pos   = PosWidth'($urandom);
        if ($urandom_range(0, 99) < push_pct) begin
          mode = MODE_PUSH;
          if (depth_guess < usable_slots(cap)) depth_guess++;
        end else begin
          pick = $urandom_range(0, 9);
          case (pick)
            0, 1, 2, 3: begin
              mode = MODE_POP;
              if (depth_guess > 0) depth_guess--;
            end
            4, 5: begin
              mode = MODE_PEEK;
              if (depth_guess > 0) pos = PosWidth'($urandom_range(1, depth_guess));
            end
            6:       mode = MODE_TOP;
            7:       mode = MODE_BOTTOM;
            8:       mode = MODE_PEEK;
            default: mode = ModeSpareLo + ModeWidth'($urandom_range(0, 2));
          endcase
        end
        issue_request(mode, value, pos, 1'b0, none);
        random_sent++;
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);

    $display("Ran %0d requests over %0d capacity settings; %0d results checked.",
             requests_sent, settings_count, results_seen);
    $display("Status mix: ok %0d, overflow %0d, underflow %0d, bad position %0d.",
             status_tally[STATUS_OK], status_tally[STATUS_OVERFLOW],
             status_tally[STATUS_UNDERFLOW], status_tally[STATUS_BAD_POS]);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bls_pkg.sv
rtl/bls_if.sv
rtl/bls_ram.sv
rtl/bls_ctrl.sv
rtl/bls_datapath.sv
rtl/bounded_lifo_stack.sv
tb/testbench.sv
